// ----- hdl/agc_pkg.sv -----
package agc_pkg;

	localparam int LOG_FRAC = 28;
	localparam int NLOG_W = 31;             // Q3.28 log2 of an 8-bit value
	localparam int GAMMA_W = 16;
	localparam int LHS_W = GAMMA_W + NLOG_W;
	localparam int CH_W = 8;
	localparam int N_STAGES = CH_W + 1;     // product stage plus one per result bit
	localparam logic [GAMMA_W-1:0] GAMMA_ONE = 16'd4096;
	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	typedef logic [NLOG_W-1:0] nlog_tbl_t [256];

	typedef struct packed {
		logic [N_STAGES-1:0] en;            // per-stage load enable
	} agc_ctl_t;

	function automatic logic [NLOG_W-1:0] lg_fix(input int unsigned x);
		int unsigned e;
		logic [63:0] m;
		logic [LOG_FRAC-1:0] f;
		e = 0;
		f = '0;
		if (x == 0) begin
			return '0;
		end
		for (int i = 1; i < 8; i++) begin
			if ((x >> i) != 0) begin
				e = i;
			end
		end
		m = 64'(x) << (31 - e);
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			f = {f[LOG_FRAC-2:0], 1'b0};
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				f[0] = 1'b1;
			end
		end
		return {3'(e), f};
	endfunction

	function automatic nlog_tbl_t build_nlog();
		nlog_tbl_t t;
		for (int x = 0; x < 256; x++) begin
			t[x] = lg_fix(255) - lg_fix(x);
		end
		return t;
	endfunction

	// N(x) = LG(255) - LG(x), evaluated at elaboration
	localparam nlog_tbl_t NLOG_TBL = build_nlog();

endpackage

// ----- hdl/agc_if.sv -----
interface agc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_alpha;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, in_alpha, in_red, in_green, in_blue, input ready);
	modport sink (input valid, in_alpha, in_red, in_green, in_blue, output ready);
endinterface

interface agc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_alpha;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

// ----- hdl/agc_lane.sv -----
module agc_lane (
	input  logic                          clk,
	input  agc_pkg::agc_ctl_t             ctl,
	input  logic [agc_pkg::GAMMA_W-1:0]   gamma,
	input  logic [agc_pkg::CH_W-1:0]      ch,
	output logic [agc_pkg::CH_W-1:0]      res
);
	import agc_pkg::*;

	logic [LHS_W-1:0] lhs_s [N_STAGES-1];
	logic [CH_W-1:0]  res_s [1:N_STAGES-1];
	logic [LHS_W-1:0] prod;

	// zero channel: never matches unless gamma is zero, then all bits match
	assign prod = (ch == '0 && gamma != '0) ? '1 : LHS_W'(gamma) * LHS_W'(NLOG_TBL[ch]);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			lhs_s[0] <= prod;
		end
	end

	// greedy search, one result bit per stage from the MSB
	for (genvar k = 1; k < N_STAGES; k++) begin : g_bit
		logic [CH_W-1:0] prev;
		logic [CH_W-1:0] cand;
		logic            fits;
		if (k == 1) begin : g_first
			assign prev = '0;
		end else begin : g_next
			assign prev = res_s[k-1];
		end
		assign cand = prev | (CH_W'(1) << (CH_W - k));
		assign fits = lhs_s[k-1] <= {4'b0, NLOG_TBL[cand], 12'b0};
		always_ff @(posedge clk) begin
			if (ctl.en[k]) begin
				res_s[k] <= fits ? cand : prev;
			end
		end
		if (k < N_STAGES - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (ctl.en[k]) begin
					lhs_s[k] <= lhs_s[k-1];
				end
			end
		end
	end

	assign res = res_s[N_STAGES-1];

endmodule

// ----- hdl/argb_gamma_correction_top.sv -----
// Pipeline: 9 register stages, the product stage loaded at acceptance, then
// 8 bit stages. Four channel lanes run side by side.
// Throughput: one item per cycle when not stalled. A stage holds when its
// successor is full and stalled, so bubbles close up under stall.
// Reset: arst_n asynchronous, clears all stage valids and sets gamma to 1.0.
module argb_gamma_correction_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [agc_pkg::GAMMA_W-1:0] cfg_wdata,
	agc_in_if.sink                      pix_in,
	agc_out_if.source                   pix_out
);
	import agc_pkg::*;

	logic [GAMMA_W-1:0]  gamma_q;
	logic [N_STAGES-1:0] v_q;
	logic [N_STAGES:0]   free;
	logic [N_STAGES-1:0] up_v;
	agc_ctl_t            ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_ONE;
		end else if (cfg_we) begin
			gamma_q <= cfg_wdata;
		end
	end

	assign free[N_STAGES] = pix_out.ready;
	assign up_v = {v_q[N_STAGES-2:0], pix_in.valid};
	for (genvar k = 0; k < N_STAGES; k++) begin : g_free
		assign free[k] = !v_q[k] || free[k+1];
	end
	assign ctl.en = free[N_STAGES-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < N_STAGES; k++) begin
				if (free[k]) begin
					v_q[k] <= up_v[k];
				end
			end
		end
	end

	assign pix_in.ready = free[0];
	assign pix_out.valid = v_q[N_STAGES-1];

	agc_lane u_alpha (.clk, .ctl, .gamma(gamma_q), .ch(pix_in.in_alpha), .res(pix_out.out_alpha));
	agc_lane u_red   (.clk, .ctl, .gamma(gamma_q), .ch(pix_in.in_red),   .res(pix_out.out_red));
	agc_lane u_green (.clk, .ctl, .gamma(gamma_q), .ch(pix_in.in_green), .res(pix_out.out_green));
	agc_lane u_blue  (.clk, .ctl, .gamma(gamma_q), .ch(pix_in.in_blue),  .res(pix_out.out_blue));

`ifndef NO_ASSERTIONS
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> v_q[0])
		else $error("accepted item not captured in first stage");
	a_gamma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && gamma_q == '0 |->
			pix_out.out_alpha == CH_MAX && pix_out.out_blue == CH_MAX)
		else $error("gamma zero must give full scale");
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[N_STAGES-1] && !pix_out.ready |=> v_q[N_STAGES-1])
		else $error("output item lost under stall");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[0] |-> pix_in.ready)
		else $error("empty first stage refused an item");
`endif

endmodule
